FILE: rtl/core/dq_pkg.sv
// Shared types, codes and sizes for the double-ended queue.
package dq_pkg;

	localparam int DQ_CAPACITY = 64;
	localparam int DQ_MAX_CAPACITY = 64;
	localparam int DQ_CNT_W = 7;
	localparam int DQ_WORD_W = 32;
	localparam int DQ_MODE_W = 3;
	localparam int DQ_STATUS_W = 2;

	localparam logic [DQ_MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [DQ_MODE_W-1:0] MODE_POP_FRONT = 3'd1;
	localparam logic [DQ_MODE_W-1:0] MODE_PUSH_BACK = 3'd2;
	localparam logic [DQ_MODE_W-1:0] MODE_POP_BACK = 3'd3;
	localparam logic [DQ_MODE_W-1:0] MODE_LIST = 3'd4;

	localparam logic [DQ_STATUS_W-1:0] STATUS_OK = 2'd0;
	localparam logic [DQ_STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [DQ_STATUS_W-1:0] STATUS_FULL = 2'd2;

	typedef struct packed {
		logic [DQ_MODE_W-1:0] mode;
		logic signed [DQ_WORD_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [DQ_STATUS_W-1:0] status;
		logic signed [DQ_WORD_W-1:0] word;
		logic last;
		logic [DQ_CNT_W-1:0] occupancy;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic apply;       // apply push/pop of the accepted transaction
		logic load_single; // load the one-result response
		logic list_start;  // latch list walk pointer and remaining count
		logic rd_en;       // read ring at walk pointer
		logic load_list;   // load one list response from read data
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic empty;
		logic list_last;
	} sts_t;

endpackage

FILE: rtl/core/double_ended_queue.sv
// Top level of the double-ended queue: controller, datapath and ports.
//
// Bounded double-ended queue of signed 32-bit words kept in a ring of CAPACITY
// entries. Each request transaction carries a mode (push front, pop front,
// push back, pop back, list) and a value. A push or pop returns one response
// with status ok, empty or full (a push into a full queue is dropped) and
// the occupancy after the operation; a list returns one response per stored
// word, front to back, with last set on the final one, or a single empty
// response when there is nothing stored. Modes 5 to 7 are ignored and return
// nothing. A push, pop or empty list is done in the accepting cycle and the
// controller stays ready for the next request, provided the response register
// is free or being drained. A list is walked after the accepting cycle: for
// every word one read of the entry RAM (registered read data) followed by a
// load of the response register, which a response stall holds up. Requests are
// stalled while a list is being walked. The entry store needs no clearing
// after reset; only occupied entries are ever read.
module double_ended_queue #(
	parameter int CAPACITY = dq_pkg::DQ_CAPACITY
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  dq_pkg::req_t  req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output dq_pkg::rsp_t  rsp
);
	import dq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing: acceptance, list walk
	dq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.mode      (req.mode),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// ring state, entry RAM and the response register
	dq_datapath #(.CAPACITY(CAPACITY)) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

FILE: rtl/core/dq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: rtl/core/dq_datapath.sv
// Ring pointers, fill count, entry store, list walker and response register.
module dq_datapath #(
	parameter int CAPACITY = dq_pkg::DQ_CAPACITY
) (
	input  logic          clk,
	input  logic          arst_n,
	input  dq_pkg::req_t  req,
	input  dq_pkg::cmd_t  cmd,
	output dq_pkg::sts_t  sts,
	input  logic          rsp_stall,
	output logic          rsp_valid,
	output dq_pkg::rsp_t  rsp
);
	import dq_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
	localparam logic [DQ_CNT_W-1:0] FULL_CNT = DQ_CNT_W'(CAPACITY);

	logic [IW-1:0] front_q, back_q, pos_q;
	logic [DQ_CNT_W-1:0] count_q, remain_q, count_next;
	logic out_valid_q;
	rsp_t out_q;

	logic empty, full, is_push, is_pop, do_push, do_pop;
	logic [IW-1:0] front_prev, front_next, back_prev, back_next, pos_next;
	logic wr_en;
	logic [IW-1:0] wr_addr;
	logic [DQ_WORD_W-1:0] rd_data;
	logic [DQ_STATUS_W-1:0] single_status;

	function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] i);
		return (i == '0) ? LAST_IDX : i - 1'b1;
	endfunction

	always_comb begin
		empty = (count_q == '0);
		full = (count_q >= FULL_CNT);
		is_push = (req.mode == MODE_PUSH_FRONT) || (req.mode == MODE_PUSH_BACK);
		is_pop = (req.mode == MODE_POP_FRONT) || (req.mode == MODE_POP_BACK);
		do_push = cmd.apply && is_push && !full;
		do_pop = cmd.apply && is_pop && !empty;
		front_prev = ring_prev(front_q);
		front_next = ring_next(front_q);
		back_prev = ring_prev(back_q);
		back_next = ring_next(back_q);
		pos_next = ring_next(pos_q);
		count_next = count_q;
		if (do_push) begin
			count_next = count_q + 1'b1;
		end else if (do_pop) begin
			count_next = count_q - 1'b1;
		end
		wr_en = do_push;
		wr_addr = (req.mode == MODE_PUSH_FRONT) ? front_prev : back_q;
		if (is_push) begin
			single_status = full ? STATUS_FULL : STATUS_OK;
		end else if (is_pop) begin
			single_status = empty ? STATUS_EMPTY : STATUS_OK;
		end else begin
			single_status = STATUS_EMPTY; // list of an empty queue
		end
		sts.out_free = !out_valid_q || !rsp_stall;
		sts.empty = empty;
		sts.list_last = (remain_q == DQ_CNT_W'(1));
	end

	dq_ram #(.WIDTH(DQ_WORD_W), .DEPTH(CAPACITY)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (req.value),
		.rd_en   (cmd.rd_en),
		.rd_addr (pos_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q <= '0;
			count_q <= '0;
			pos_q <= '0;
			remain_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (do_push && req.mode == MODE_PUSH_FRONT) front_q <= front_prev;
			if (do_push && req.mode == MODE_PUSH_BACK) back_q <= back_next;
			if (do_pop && req.mode == MODE_POP_FRONT) front_q <= front_next;
			if (do_pop && req.mode == MODE_POP_BACK) back_q <= back_prev;
			if (cmd.list_start) begin
				pos_q <= front_q;
				remain_q <= count_q;
			end else if (cmd.load_list) begin
				pos_q <= pos_next;
				remain_q <= remain_q - 1'b1;
			end
			if (cmd.load_single || cmd.load_list) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_single) begin
			out_q.status <= single_status;
			out_q.word <= '0;
			out_q.last <= 1'b1;
			out_q.occupancy <= count_next;
		end else if (cmd.load_list) begin
			out_q.status <= STATUS_OK;
			out_q.word <= rd_data;
			out_q.last <= sts.list_last;
			out_q.occupancy <= count_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT) else $error("fill count above capacity");
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> front_q == back_q) else $error("empty ring with split pointers");
	a_full_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == FULL_CNT |-> front_q == back_q) else $error("full ring with split pointers");
	a_list_remain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_list |-> remain_q != '0) else $error("list load with nothing left");

endmodule

FILE: rtl/core/dq_ctrl.sv
// Controller: transaction acceptance and list walk sequencing.
module dq_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic [dq_pkg::DQ_MODE_W-1:0]  mode,
	output logic                          req_stall,
	input  dq_pkg::sts_t                  sts,
	output dq_pkg::cmd_t                  cmd
);
	import dq_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LIST_RD = 2'd1;
	localparam logic [1:0] ST_LIST_OUT = 2'd2;

	logic [1:0] state_q, state_next;
	logic accept;

	always_comb begin
		req_stall = !(state_q == ST_IDLE && sts.out_free);
		accept = req_valid && !req_stall;
		cmd = '0;
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (mode)
						MODE_PUSH_FRONT, MODE_POP_FRONT, MODE_PUSH_BACK, MODE_POP_BACK: begin
							cmd.apply = 1'b1;
							cmd.load_single = 1'b1;
						end
						MODE_LIST: begin
							if (sts.empty) begin
								cmd.load_single = 1'b1;
							end else begin
								cmd.list_start = 1'b1;
								state_next = ST_LIST_RD;
							end
						end
						default: ; // unused modes: no response
					endcase
				end
			end
			ST_LIST_RD: begin
				cmd.rd_en = 1'b1;
				state_next = ST_LIST_OUT;
			end
			ST_LIST_OUT: begin
				if (sts.out_free) begin
					cmd.load_list = 1'b1;
					state_next = sts.list_last ? ST_IDLE : ST_LIST_RD;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule
